// ===== hw/rtl/battery_charger_monitor_macros.svh =====
// assertion helpers for the charger monitor checks
`ifndef BATTERY_CHARGER_MONITOR_MACROS_SVH
`define BATTERY_CHARGER_MONITOR_MACROS_SVH

// checked only outside reset
`define BCM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked at every edge, reset included
`define BCM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/bcm_pkg.sv =====
`default_nettype none

package bcm_pkg;

  localparam int unsigned StepW = 3;
  typedef logic [StepW-1:0] step_t;

  localparam step_t StepIdle  = 3'd0;
  localparam step_t StepMulVc = 3'd1;
  localparam step_t StepMulV5 = 3'd2;
  localparam step_t StepMulEs = 3'd3;
  localparam step_t StepMulI6 = 3'd4;
  localparam step_t StepMulU1 = 3'd5;
  localparam step_t StepPct   = 3'd6;
  localparam step_t StepOut   = 3'd7;

  // arithmetic constants
  localparam logic [22:0] MvRecip   = 23'd5125004;  // floor(5000 * 2^20 / 1023)
  localparam logic [22:0] MvScale   = 23'd5000;
  localparam logic [22:0] MvDiv     = 23'd1023;
  localparam logic [22:0] MaScale   = 23'd600;
  localparam logic [22:0] PctRecip  = 23'd171;      // 1/3 in q9
  localparam logic [9:0]  IrawMid   = 10'd512;
  localparam logic [12:0] PctLowMv  = 13'd3000;
  localparam logic [12:0] PctHighMv = 13'd4200;
  localparam logic [6:0]  PctFull   = 7'd100;
  localparam logic [6:0]  PctNone   = 7'd0;
  localparam logic [7:0]  StatusBlank = 8'hFF;
  localparam int unsigned StatusDoneBit = 1;
  localparam int unsigned VbusBit       = 0;

  localparam logic [1:0] ChgNone     = 2'd0;
  localparam logic [1:0] ChgComplete = 2'd1;
  localparam logic [1:0] ChgActive   = 2'd2;

  typedef enum logic [2:0] {
    MulNone,
    MulVrawRecip,
    MulVrawScale,
    MulEstDiv,
    MulImagScale,
    MulPctRecip
  } mul_sel_e;

  typedef enum logic [2:0] {
    WbNone,
    WbEst,
    WbAcc,
    WbFix,
    WbMa,
    WbPct,
    WbOut
  } wb_sel_e;

  typedef enum logic [1:0] {
    CondAlways,
    CondInItem,
    CondOutFree
  } cond_e;

  typedef struct packed {
    mul_sel_e mul_sel;
    wb_sel_e  wb_sel;
    cond_e    cond;
    step_t    next;
  } ctrl_t;

  // microprogram: a step advances to next when its condition holds, else it waits
  function automatic ctrl_t bcm_ucode(input step_t step);
    ctrl_t cw;
    cw = '{mul_sel: MulNone, wb_sel: WbNone, cond: CondAlways, next: StepIdle};
    case (step)
      StepIdle:  cw = '{mul_sel: MulNone,      wb_sel: WbNone, cond: CondInItem,
                       next: StepMulVc};
      StepMulVc: cw = '{mul_sel: MulVrawRecip, wb_sel: WbNone, cond: CondAlways,
                       next: StepMulV5};
      StepMulV5: cw = '{mul_sel: MulVrawScale, wb_sel: WbEst,  cond: CondAlways,
                       next: StepMulEs};
      StepMulEs: cw = '{mul_sel: MulEstDiv,    wb_sel: WbAcc,  cond: CondAlways,
                       next: StepMulI6};
      StepMulI6: cw = '{mul_sel: MulImagScale, wb_sel: WbFix,  cond: CondAlways,
                       next: StepMulU1};
      StepMulU1: cw = '{mul_sel: MulPctRecip,  wb_sel: WbMa,   cond: CondAlways,
                       next: StepPct};
      StepPct:   cw = '{mul_sel: MulNone,      wb_sel: WbPct,  cond: CondAlways,
                       next: StepOut};
      StepOut:   cw = '{mul_sel: MulNone,      wb_sel: WbOut,  cond: CondOutFree,
                       next: StepIdle};
      default:   cw = '{mul_sel: MulNone,      wb_sel: WbNone, cond: CondAlways,
                       next: StepIdle};
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/battery_charger_monitor.sv =====
// Charger poll monitor.
// Input channel (in_valid_i / in_ready_o) takes one poll sample per item: force flag,
// current-state byte, raw ADC bytes, charger status and VBUS status.
// Output channel (out_valid_o / out_ready_i) returns battery voltage in mV, signed
// current in mA, charge percent, the changed and restart flags and the charge state.
// Config channel (cfg_valid_i / cfg_ready_o) writes monitor_enable; always ready.
// With monitor_enable low an item is taken and dropped: no result, state untouched.
// A small microprogram runs the sample through one shared 13x23 multiplier, one
// product per step: five products, then percent and the output load.
// The result is loaded into the output register at the output step; in_ready_o is high
// only in the idle step, so a new item is not taken until the program is back in idle.
// The result sits in an output register; the next item is taken while it waits.
// If the receiver stalls with a result still pending, the program holds at its
// output step and in_ready_o stays low until the register frees.
// Reset clears enable, the poll history and the output valid; the first enabled
// poll after reset always reports changed.
`default_nettype none

module battery_charger_monitor import bcm_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic               cfg_monitor_enable_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               force_report_i,
  input  wire logic [7:0]         current_state_code_i,
  input  wire logic [7:0]         vbat_high_bits_i,
  input  wire logic [7:0]         low_bits_a_i,
  input  wire logic [7:0]         ibat_high_bits_i,
  input  wire logic [7:0]         low_bits_b_i,
  input  wire logic [7:0]         charger_status_i,
  input  wire logic [7:0]         vbus_flags_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [12:0]             battery_mv_o,
  output logic signed [10:0]      battery_ma_o,
  output logic [6:0]              battery_percent_o,
  output logic                    changed_o,
  output logic                    restart_charger_o,
  output logic [1:0]              charge_state_o
);

  logic        en_q;
  step_t       step_q, step_d;
  ctrl_t       cw;
  logic        cond_ok;
  logic        in_acc, take;
  logic        out_free;

  logic [7:0]  prev_status_q;
  logic [7:0]  prev_cur_q;
  logic        prev_vbus_q;
  logic        first_done_q;
  logic        restart_issued_q;

  logic [9:0]  vraw_q;
  logic [9:0]  imag_q;
  logic        ineg_q;
  logic        chg_q;
  logic        restart_q;
  logic [1:0]  cstate_q;

  logic [32:0] prod_q;
  logic [22:0] acc_q;
  logic [12:0] mv_q;
  logic [10:0] ma_q;
  logic [6:0]  pct_q;

  logic [12:0] mul_a;
  logic [22:0] mul_b;
  logic [32:0] mul_p;
  logic [22:0] fix_diff;
  logic [12:0] pct_off;
  logic [9:0]  ma_mag;

  logic [9:0]  iraw;
  logic        vbus_now;
  logic        chg_now;
  logic [1:0]  cstate_now;

  logic        out_valid_q;
  logic [12:0] out_mv_q;
  logic [10:0] out_ma_q;
  logic [6:0]  out_pct_q;
  logic        out_chg_q;
  logic        out_restart_q;
  logic [1:0]  out_cstate_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (step_q == StepIdle);
  assign in_acc      = in_valid_i & in_ready_o;
  assign take        = in_acc & en_q;
  assign out_free    = ~out_valid_q | out_ready_i;

  assign cw = bcm_ucode(step_q);

  always_comb begin
    case (cw.cond)
      CondAlways:  cond_ok = 1'b1;
      CondInItem:  cond_ok = take;
      CondOutFree: cond_ok = out_free;
      default:     cond_ok = 1'b1;
    endcase
    step_d = cond_ok ? cw.next : step_q;
  end

  // sample decode
  assign iraw     = {ibat_high_bits_i, low_bits_b_i[5:4]};
  assign vbus_now = vbus_flags_i[VbusBit];
  assign chg_now  = force_report_i | ~first_done_q
                  | (charger_status_i != prev_status_q)
                  | (current_state_code_i != prev_cur_q)
                  | (vbus_now != prev_vbus_q);

  always_comb begin
    if (!vbus_now) begin
      cstate_now = ChgNone;
    end else if ((charger_status_i != StatusBlank) && charger_status_i[StatusDoneBit]) begin
      cstate_now = ChgComplete;
    end else begin
      cstate_now = ChgActive;
    end
  end

  // shared multiplier
  assign pct_off = mv_q - PctLowMv;

  always_comb begin
    case (cw.mul_sel)
      MulVrawRecip: begin
        mul_a = {3'b000, vraw_q};
        mul_b = MvRecip;
      end
      MulVrawScale: begin
        mul_a = {3'b000, vraw_q};
        mul_b = MvScale;
      end
      MulEstDiv: begin
        mul_a = mv_q;
        mul_b = MvDiv;
      end
      MulImagScale: begin
        mul_a = {3'b000, imag_q};
        mul_b = MaScale;
      end
      MulPctRecip: begin
        mul_a = {2'b00, pct_off[12:2]};
        mul_b = PctRecip;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p    = {20'b0, mul_a} * {10'b0, mul_b};
  assign fix_diff = acc_q - prod_q[22:0];
  assign ma_mag   = prod_q[18:9];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q             <= 1'b0;
      step_q           <= StepIdle;
      prev_status_q    <= StatusBlank;
      prev_cur_q       <= StatusBlank;
      prev_vbus_q      <= 1'b0;
      first_done_q     <= 1'b0;
      restart_issued_q <= 1'b0;
      out_valid_q      <= 1'b0;
    end else begin
      step_q <= step_d;
      if (cfg_valid_i) begin
        en_q <= cfg_monitor_enable_i;
      end
      if (take) begin
        prev_status_q    <= charger_status_i;
        prev_cur_q       <= current_state_code_i;
        prev_vbus_q      <= vbus_now;
        first_done_q     <= 1'b1;
        restart_issued_q <= vbus_now;
      end
      if (cw.wb_sel == WbOut && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (take) begin
      vraw_q    <= {vbat_high_bits_i, low_bits_a_i[7:6]};
      ineg_q    <= ~iraw[9];
      imag_q    <= iraw[9] ? {1'b0, iraw[8:0]} : (IrawMid - iraw);
      chg_q     <= chg_now;
      restart_q <= vbus_now & ~restart_issued_q;
      cstate_q  <= cstate_now;
    end
    if (cw.mul_sel != MulNone) begin
      prod_q <= mul_p;
    end
    case (cw.wb_sel)
      WbEst: mv_q  <= prod_q[32:20];
      WbAcc: acc_q <= prod_q[22:0];
      WbFix: begin
        if (fix_diff >= MvDiv) begin
          mv_q <= mv_q + 13'd1;
        end
      end
      WbMa:  ma_q  <= ineg_q ? (11'd0 - {1'b0, ma_mag}) : {1'b0, ma_mag};
      WbPct: begin
        if (mv_q >= PctHighMv) begin
          pct_q <= PctFull;
        end else if (mv_q <= PctLowMv) begin
          pct_q <= PctNone;
        end else begin
          pct_q <= prod_q[15:9];
        end
      end
      WbOut: begin
        if (out_free) begin
          out_mv_q      <= mv_q;
          out_ma_q      <= ma_q;
          out_pct_q     <= pct_q;
          out_chg_q     <= chg_q;
          out_restart_q <= restart_q;
          out_cstate_q  <= cstate_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o       = out_valid_q;
  assign battery_mv_o      = out_mv_q;
  assign battery_ma_o      = $signed(out_ma_q);
  assign battery_percent_o = out_pct_q;
  assign changed_o         = out_chg_q;
  assign restart_charger_o = out_restart_q;
  assign charge_state_o    = out_cstate_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bcm_checker.sv =====
`default_nettype none

`include "battery_charger_monitor_macros.svh"

module bcm_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_ready_o,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire logic [12:0]       battery_mv_o,
  input wire logic signed [10:0] battery_ma_o,
  input wire logic [6:0]        battery_percent_o,
  input wire logic              changed_o,
  input wire logic [1:0]        charge_state_o
);

  // a stalled item holds
  `BCM_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(battery_mv_o) && $stable(battery_ma_o) && $stable(changed_o), "stalled result changed")

  // a fresh result is loaded as the sequencer returns to idle
  `BCM_ASSERT(a_rise_idle, clk_i, rst_ni, $rose(out_valid_o) |-> in_ready_o, "result appeared while busy")

  // result ranges
  `BCM_ASSERT(a_out_range, clk_i, rst_ni, out_valid_o |-> (battery_percent_o <= 7'd100) && (battery_mv_o <= 13'd5000) && (charge_state_o != 2'd3), "result out of range")

  `BCM_ASSERT(a_ma_range, clk_i, rst_ni, out_valid_o |-> (battery_ma_o >= -11'sd600) && (battery_ma_o <= 11'sd598), "current out of range")

  // nothing pending during reset
  `BCM_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !out_valid_o, "output valid in reset")

endmodule

bind battery_charger_monitor bcm_checker u_bcm_checker (.*);

`default_nettype wire
